[sv/dss_pkg.sv]
// ----------------------------------------------------------------------------
// dss_pkg: shared constants and helpers for the seek total block
// Register indexes, algorithm codes, field widths and a distance helper.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int CYL_IN_W      = 16;
    localparam int CYL_W_MAX     = 24;
    localparam int TOTAL_W       = 26;
    localparam int ALG_W         = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam int MAX_REQ_DEF   = 1024;
    localparam int CYL_BITS_DEF  = 16;

    localparam logic [CFG_DATA_W-1:0] TOP_RESET = 16'd4999;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_CYL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM  = 2'd2;

    // algorithm codes
    localparam logic [ALG_W-1:0] ALG_FCFS  = 3'd0;
    localparam logic [ALG_W-1:0] ALG_SSTF  = 3'd1;
    localparam logic [ALG_W-1:0] ALG_SCAN  = 3'd2;
    localparam logic [ALG_W-1:0] ALG_CSCAN = 3'd3;
    localparam logic [ALG_W-1:0] ALG_LOOK  = 3'd4;
    localparam logic [ALG_W-1:0] ALG_CLOOK = 3'd5;

    // absolute difference of two cylinders
    function automatic logic [CYL_W_MAX-1:0] abs_diff(input logic [CYL_W_MAX-1:0] a,
                                                     input logic [CYL_W_MAX-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

[sv/dss_if.sv]
// ----------------------------------------------------------------------------
// dss_req_if / dss_res_if: valid/ready channels of the seek total block
// Request channel carries one cylinder; result channel carries the total.
// ----------------------------------------------------------------------------
interface dss_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] cylinder;
    logic        last_request;

    modport source (output valid, output cylinder, output last_request, input ready);
    modport sink   (input valid, input cylinder, input last_request, output ready);
endinterface

interface dss_res_if;
    logic        valid;
    logic        ready;
    logic [25:0] total_movement;
    logic        overflow;

    modport source (output valid, output total_movement, output overflow, input ready);
    modport sink   (input valid, input total_movement, input overflow, output ready);
endinterface

[sv/dss_req_mem.sv]
// ----------------------------------------------------------------------------
// dss_req_mem: request store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dss_req_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[sv/dss_sweep_calc.sv]
// ----------------------------------------------------------------------------
// dss_sweep_calc: sweep totals from the batch extremes
// SCAN, C-SCAN, LOOK and C-LOOK totals from the lowest and highest request
// on each side of the head.
// ----------------------------------------------------------------------------
module dss_sweep_calc #(
    parameter int CYL_BITS = 16
) (
    input  logic [dss_pkg::ALG_W-1:0]    i_alg,
    input  logic [CYL_BITS-1:0]          i_head,
    input  logic [CYL_BITS-1:0]          i_top,
    input  logic                         i_below,
    input  logic                         i_above,
    input  logic [CYL_BITS-1:0]          i_min_below,
    input  logic [CYL_BITS-1:0]          i_max_below,
    input  logic [CYL_BITS-1:0]          i_min_above,
    input  logic [CYL_BITS-1:0]          i_max_above,
    output logic [dss_pkg::TOTAL_W-1:0]  o_total
);
    import dss_pkg::*;

    localparam int SW = CYL_BITS + 2;

    logic [CYL_W_MAX-1:0] w_h, w_t, w_minb, w_maxb, w_mina, w_maxa, w_pos;
    logic [SW-1:0]        w_sum;

    assign w_h    = CYL_W_MAX'(i_head);
    assign w_t    = CYL_W_MAX'(i_top);
    assign w_minb = CYL_W_MAX'(i_min_below);
    assign w_maxb = CYL_W_MAX'(i_max_below);
    assign w_mina = CYL_W_MAX'(i_min_above);
    assign w_maxa = CYL_W_MAX'(i_max_above);

    always_comb begin
        w_sum = '0;
        w_pos = w_h;
        priority if (i_alg == ALG_SCAN) begin
            if (i_below) begin
                w_sum = SW'(w_h);
                w_pos = '0;
            end
            if (i_above) w_sum = w_sum + SW'(abs_diff(w_maxa, w_pos));
        end else if (i_alg == ALG_CSCAN) begin
            if (i_below) begin
                w_sum = SW'(w_h);
                w_pos = '0;
            end
            if (i_above) begin
                w_sum = w_sum + SW'(abs_diff(w_t, w_pos)) + SW'(abs_diff(w_t, w_mina));
            end
        end else if (i_alg == ALG_LOOK) begin
            if (i_above) begin
                w_sum = SW'(abs_diff(w_maxa, w_h));
                w_pos = w_maxa;
            end
            if (i_below) w_sum = w_sum + SW'(abs_diff(w_pos, w_minb));
        end else begin
            // C-LOOK
            if (i_above) begin
                w_sum = SW'(abs_diff(w_maxa, w_h));
                w_pos = w_maxa;
            end
            if (i_below) begin
                w_sum = w_sum + SW'(abs_diff(w_pos, w_minb)) + SW'(abs_diff(w_maxb, w_minb));
            end
        end
    end

    assign o_total = TOTAL_W'(w_sum);
endmodule

[sv/disk_schedule_seek_total.sv]
// ----------------------------------------------------------------------------
// disk_schedule_seek_total: total head movement of a batch of disk requests
// Loads cylinder requests and computes the seek total for the chosen policy.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one cylinder per transaction; last_request closes a batch.
//   o_res carries one result per batch: total_movement and overflow.
//   Configuration (head_start, top_cylinder, algorithm) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Flow:
//   Loading takes one request per cycle while i_req is ready. FCFS, SCAN, C-SCAN, LOOK and C-LOOK
//   give the result through the ST_SWEEP state and the output register, from the running
//   arrival sum and the per-side extremes kept during loading.
//   SSTF walks the request store once per served request through the single
//   read port of the store; i_req is not ready during the walk.
// Reset:
//   Synchronous, active low; registers return to their reset values and the
//   batch is empty. The store needs no clearing: entries are marked unserved
//   as they are loaded.
// Stall:
//   The result is held in an output register until taken. Requests that do
//   not close a batch are still taken meanwhile; a closing one waits.
// ----------------------------------------------------------------------------
module disk_schedule_seek_total #(
    parameter int MAX_REQUESTS = dss_pkg::MAX_REQ_DEF,
    parameter int CYL_BITS     = dss_pkg::CYL_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dss_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    dss_req_if.sink                         i_req,
    dss_res_if.source                       o_res
);
    import dss_pkg::*;

    localparam int AW = $clog2(MAX_REQUESTS);
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int MW = CYL_BITS + 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REQUESTS);
    localparam logic [TOTAL_W:0] SAT_LIM = {1'b0, {TOTAL_W{1'b1}}};

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_MARK  = 2'd3;

    // configuration registers
    logic [CFG_DATA_W-1:0] r_head_start, r_top;
    logic [ALG_W-1:0]      r_alg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_start <= '0;
            r_top        <= TOP_RESET;
            r_alg        <= ALG_FCFS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HEAD_START: r_head_start <= i_cfg_data;
                REG_TOP_CYL:    r_top        <= i_cfg_data;
                REG_ALGORITHM:  r_alg        <= ALG_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // batch state
    logic [1:0]          r_state;
    logic [CW-1:0]       r_count;
    logic                r_dropped;
    logic [CYL_BITS-1:0] r_batch_head, r_prev;
    logic [TOTAL_W-1:0]  r_sum;
    logic                r_below, r_above;
    logic [CYL_BITS-1:0] r_min_b, r_max_b, r_min_a, r_max_a;

    // SSTF sequencer
    logic [CW-1:0]       r_addr, r_served;
    logic                r_rd_vld;
    logic [AW-1:0]       r_rd_idx;
    logic                r_found;
    logic [AW-1:0]       r_best_idx;
    logic [CYL_BITS-1:0] r_best_cyl, r_best_d, r_pos;
    logic [TOTAL_W-1:0]  r_total;

    // result register
    logic                r_out_valid;
    logic [TOTAL_W-1:0]  r_out_total;
    logic                r_out_ovf;

    // load path
    logic                w_acc, w_first, w_store;
    logic [CYL_BITS-1:0] w_cyl, w_bh, w_prev;
    logic [TOTAL_W-1:0]  w_sum_base;
    logic [TOTAL_W:0]    w_sum_raw;
    logic                n_below, n_above;
    logic [CYL_BITS-1:0] n_min_b, n_max_b, n_min_a, n_max_a;

    assign i_req.ready = (r_state == ST_LOAD) && (!r_out_valid || !i_req.last_request);
    assign w_acc   = i_req.valid && i_req.ready;
    assign w_cyl   = CYL_BITS'(i_req.cylinder);
    assign w_first = (r_count == '0) && !r_dropped;
    assign w_bh    = w_first ? CYL_BITS'(r_head_start) : r_batch_head;
    assign w_prev  = w_first ? w_bh : r_prev;
    assign w_sum_base = w_first ? '0 : r_sum;
    assign w_store = r_count < CNT_MAX;
    assign w_sum_raw = {1'b0, w_sum_base}
                     + (TOTAL_W + 1)'(abs_diff(CYL_W_MAX'(w_cyl), CYL_W_MAX'(w_prev)));

    // per-side extremes, relative to the batch head
    always_comb begin
        n_below = w_first ? 1'b0 : r_below;
        n_above = w_first ? 1'b0 : r_above;
        n_min_b = r_min_b;
        n_max_b = r_max_b;
        n_min_a = r_min_a;
        n_max_a = r_max_a;
        if (w_cyl < w_bh) begin
            if (!n_below || w_cyl < n_min_b) n_min_b = w_cyl;
            if (!n_below || w_cyl > n_max_b) n_max_b = w_cyl;
            n_below = 1'b1;
        end else if (w_cyl > w_bh) begin
            if (!n_above || w_cyl < n_min_a) n_min_a = w_cyl;
            if (!n_above || w_cyl > n_max_a) n_max_a = w_cyl;
            n_above = 1'b1;
        end
    end

    // request store: {served mark, cylinder}
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [MW-1:0]     w_wdata;
    logic [MW-1:0]     w_rdata;
    logic              w_mark;
    logic [CYL_BITS-1:0] w_rcyl, w_rd_d;
    logic              w_better;

    assign w_we    = (w_acc && w_store) || (r_state == ST_MARK);
    assign w_waddr = (r_state == ST_MARK) ? r_best_idx : r_count[AW-1:0];
    assign w_wdata = (r_state == ST_MARK) ? {1'b1, r_best_cyl} : {1'b0, w_cyl};

    dss_req_mem #(.DEPTH(MAX_REQUESTS), .WIDTH(MW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // shared compare unit of the SSTF walk
    assign w_mark   = w_rdata[MW-1];
    assign w_rcyl   = w_rdata[CYL_BITS-1:0];
    assign w_rd_d   = CYL_BITS'(abs_diff(CYL_W_MAX'(w_rcyl), CYL_W_MAX'(r_pos)));
    assign w_better = !r_found || (w_rd_d < r_best_d)
                   || ((w_rd_d == r_best_d) && (w_rcyl > r_best_cyl));

    logic [TOTAL_W:0] w_tot_raw;
    assign w_tot_raw = {1'b0, r_total} + (TOTAL_W + 1)'(r_best_d);

    // sweep totals
    logic [TOTAL_W-1:0] w_sweep_total;

    dss_sweep_calc #(.CYL_BITS(CYL_BITS)) u_sweep (
        .i_alg       (r_alg),
        .i_head      (r_batch_head),
        .i_top       (CYL_BITS'(r_top)),
        .i_below     (r_below),
        .i_above     (r_above),
        .i_min_below (r_min_b),
        .i_max_below (r_max_b),
        .i_min_above (r_min_a),
        .i_max_above (r_max_a),
        .o_total     (w_sweep_total)
    );

    logic w_is_sweep;
    assign w_is_sweep = (r_alg == ALG_SCAN) || (r_alg == ALG_CSCAN)
                     || (r_alg == ALG_LOOK) || (r_alg == ALG_CLOOK);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_LOAD: begin
                    if (w_acc) begin
                        r_batch_head <= w_bh;
                        if (w_store) begin
                            r_sum   <= (w_sum_raw > SAT_LIM) ? SAT_LIM[TOTAL_W-1:0]
                                                             : w_sum_raw[TOTAL_W-1:0];
                            r_prev  <= w_cyl;
                            r_count <= r_count + 1'b1;
                            r_below <= n_below;
                            r_above <= n_above;
                            r_min_b <= n_min_b;
                            r_max_b <= n_max_b;
                            r_min_a <= n_min_a;
                            r_max_a <= n_max_a;
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_req.last_request) begin
                            r_addr   <= '0;
                            r_served <= '0;
                            r_found  <= 1'b0;
                            r_pos    <= w_bh;
                            r_total  <= '0;
                            r_state  <= (r_alg == ALG_SSTF) ? ST_SCAN : ST_SWEEP;
                        end
                    end
                end
                ST_SWEEP: begin
                    r_out_valid <= 1'b1;
                    r_out_total <= w_is_sweep ? w_sweep_total : r_sum;
                    r_out_ovf   <= r_dropped;
                    r_count     <= '0;
                    r_dropped   <= 1'b0;
                    r_state     <= ST_LOAD;
                end
                ST_SCAN: begin
                    // issue reads in order, compare each read word in the next cycle
                    if (r_addr < r_count) begin
                        r_addr   <= r_addr + 1'b1;
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_addr[AW-1:0];
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (r_rd_vld && !w_mark && w_better) begin
                        r_found    <= 1'b1;
                        r_best_idx <= r_rd_idx;
                        r_best_cyl <= w_rcyl;
                        r_best_d   <= w_rd_d;
                    end
                    if (r_addr == r_count && !r_rd_vld) r_state <= ST_MARK;
                end
                ST_MARK: begin
                    // serve the nearest request (store write is done by the mux)
                    r_total  <= (w_tot_raw > SAT_LIM) ? SAT_LIM[TOTAL_W-1:0]
                                                      : w_tot_raw[TOTAL_W-1:0];
                    r_pos    <= r_best_cyl;
                    r_served <= r_served + 1'b1;
                    r_addr   <= '0;
                    r_found  <= 1'b0;
                    if (!r_found || (r_served + 1'b1) >= r_count) begin
                        r_out_valid <= 1'b1;
                        r_out_total <= r_found ? ((w_tot_raw > SAT_LIM)
                                                  ? SAT_LIM[TOTAL_W-1:0]
                                                  : w_tot_raw[TOTAL_W-1:0])
                                               : r_total;
                        r_out_ovf   <= r_dropped;
                        r_count     <= '0;
                        r_dropped   <= 1'b0;
                        r_state     <= ST_LOAD;
                    end else begin
                        r_state <= ST_SCAN;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.total_movement = r_out_total;
    assign o_res.overflow       = r_out_ovf;
endmodule
